@@ design/clt_pkg.sv @@
// Shared types and constants for the command line tokenizer.
// Holds the result and bundle formats passed from the lexer front end to the output side.
// No dependencies.
package clt_pkg;

  localparam int unsigned MaxResults = 5;
  localparam int unsigned CountW     = 3;

  typedef enum logic [2:0] {
    KIND_QUOTE   = 3'd0,
    KIND_NUMBER  = 3'd1,
    KIND_OP      = 3'd2,
    KIND_BRACKET = 3'd3,
    KIND_WORD    = 3'd4
  } kind_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       valid;
    logic       tend;
    kind_e      kind;
    logic       cmd_end;
  } result_t;

  // All results that one character causes, in order, with their number.
  typedef struct packed {
    result_t [MaxResults-1:0] res;
    logic [CountW-1:0]        count;
  } bundle_t;

endpackage

@@ design/clt_front.sv @@
// Lexer front end of the command line tokenizer: accepts characters, keeps the lexer
// state and turns each character into a bundle of up to five results.
// Depends on clt_pkg.
module clt_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       char_in_i,
  input  logic             last_char_i,
  input  logic             queue_full_i,
  output logic             push_o,
  output clt_pkg::bundle_t bundle_o
);
  import clt_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE  = 3'd0,
    M_QUOTE = 3'd1,
    M_QESC  = 3'd2,
    M_NUM   = 3'd3,
    M_WORD  = 3'd4,
    M_OPH   = 3'd5,
    M_DOTH  = 3'd6
  } mode_e;

  localparam logic [7:0] ChQuote  = 8'd34;
  localparam logic [7:0] ChBslash = 8'd92;
  localparam logic [7:0] ChDot    = 8'd46;
  localparam logic [7:0] ChEq     = 8'd61;
  localparam logic [7:0] ChBang   = 8'd33;
  localparam logic [7:0] ChLt     = 8'd60;
  localparam logic [7:0] ChGt     = 8'd62;
  localparam logic [7:0] ChStar   = 8'd42;

  mode_e      mode_q, mode_d;
  logic [7:0] held_q, held_d;
  logic       dot_q, dot_d;
  logic       drop_q, drop_d;
  logic       start;
  logic       pair;
  logic       accept;
  logic [7:0] c;
  logic [7:0] esc_ch;
  bundle_t    b;

  function automatic logic is_digit(logic [7:0] x);
    return x >= 8'd48 && x <= 8'd57;
  endfunction

  function automatic logic is_alpha(logic [7:0] x);
    return (x >= 8'd65 && x <= 8'd90) || (x >= 8'd97 && x <= 8'd122);
  endfunction

  function automatic logic is_wsym(logic [7:0] x);
    return x == 8'd92 || x == 8'd47 || x == 8'd46 || x == 8'd91 || x == 8'd93;
  endfunction

  function automatic logic is_op(logic [7:0] x);
    return x == 8'd61 || x == 8'd33 || x == 8'd60 || x == 8'd62 ||
           x == 8'd43 || x == 8'd45 || x == 8'd42 || x == 8'd47;
  endfunction

  function automatic logic is_bracket(logic [7:0] x);
    return x == 8'd40 || x == 8'd41 || x == 8'd123 || x == 8'd125;
  endfunction

  function automatic logic [7:0] unescape(logic [7:0] x);
    logic [7:0] r;
    unique case (x)
      8'd110:  r = 8'd10;
      8'd116:  r = 8'd9;
      8'd114:  r = 8'd13;
      8'd48:   r = 8'd0;
      default: r = x;
    endcase
    return r;
  endfunction

  // Appends one result; anything past the fifth is dropped.
  function automatic bundle_t put(bundle_t bi, logic [7:0] ch, logic v, logic e, kind_e k);
    bundle_t bo;
    bo = bi;
    if (bi.count < CountW'(MaxResults)) begin
      bo.res[bi.count] = '{ch: ch, valid: v, tend: e, kind: k, cmd_end: 1'b0};
      bo.count = bi.count + CountW'(1);
    end
    return bo;
  endfunction

  assign c      = char_in_i;
  assign esc_ch = unescape(char_in_i);
  assign pair   = (c == ChEq && (held_q == ChEq || held_q == ChBang ||
                                 held_q == ChLt || held_q == ChGt)) ||
                  (c == ChStar && held_q == ChStar);

  always_comb begin
    b      = '0;
    mode_d = mode_q;
    held_d = held_q;
    dot_d  = dot_q;
    drop_d = drop_q;
    start  = 1'b0;

    unique case (mode_q)
      M_QUOTE: begin
        if (c == ChQuote) begin
          b      = put(b, 8'd0, 1'b0, 1'b1, KIND_QUOTE);
          mode_d = M_IDLE;
        end else if (c == ChBslash && !last_char_i) begin
          mode_d = M_QESC;
        end else if (!drop_q) begin
          if (c == 8'd0) drop_d = 1'b1;
          else b = put(b, c, 1'b1, 1'b0, KIND_QUOTE);
        end
      end
      M_QESC: begin
        if (!drop_q) begin
          if (esc_ch == 8'd0) drop_d = 1'b1;
          else b = put(b, esc_ch, 1'b1, 1'b0, KIND_QUOTE);
        end
        mode_d = M_QUOTE;
      end
      M_NUM: begin
        if (is_digit(c)) begin
          b = put(b, c, 1'b1, 1'b0, KIND_NUMBER);
        end else if (c == ChDot && !dot_q) begin
          b     = put(b, c, 1'b1, 1'b0, KIND_NUMBER);
          dot_d = 1'b1;
        end else begin
          b     = put(b, 8'd0, 1'b0, 1'b1, KIND_NUMBER);
          start = 1'b1;
        end
      end
      M_WORD: begin
        if (is_alpha(c) || is_digit(c) || is_wsym(c)) begin
          b = put(b, c, 1'b1, 1'b0, KIND_WORD);
        end else begin
          b     = put(b, 8'd0, 1'b0, 1'b1, KIND_WORD);
          start = 1'b1;
        end
      end
      M_OPH: begin
        b      = put(b, held_q, 1'b1, 1'b0, KIND_OP);
        mode_d = M_IDLE;
        if (pair) begin
          b = put(b, c, 1'b1, 1'b0, KIND_OP);
          b = put(b, 8'd0, 1'b0, 1'b1, KIND_OP);
        end else begin
          b     = put(b, 8'd0, 1'b0, 1'b1, KIND_OP);
          start = 1'b1;
        end
      end
      M_DOTH: begin
        if (is_digit(c)) begin
          b      = put(b, ChDot, 1'b1, 1'b0, KIND_NUMBER);
          b      = put(b, c, 1'b1, 1'b0, KIND_NUMBER);
          dot_d  = 1'b1;
          mode_d = M_NUM;
        end else begin
          b = put(b, ChDot, 1'b1, 1'b0, KIND_WORD);
          if (is_alpha(c) || is_digit(c) || is_wsym(c)) begin
            b      = put(b, c, 1'b1, 1'b0, KIND_WORD);
            mode_d = M_WORD;
          end else begin
            b     = put(b, 8'd0, 1'b0, 1'b1, KIND_WORD);
            start = 1'b1;
          end
        end
      end
      default: start = 1'b1;
    endcase

    // A character that arrives with no token open, or that ends the open token.
    if (start) begin
      mode_d = M_IDLE;
      priority if (c == ChQuote) begin
        mode_d = M_QUOTE;
        drop_d = 1'b0;
      end else if (is_digit(c)) begin
        b      = put(b, c, 1'b1, 1'b0, KIND_NUMBER);
        dot_d  = 1'b0;
        mode_d = M_NUM;
      end else if (c == ChDot) begin
        held_d = c;
        mode_d = M_DOTH;
      end else if (is_op(c)) begin
        if (c == ChEq || c == ChBang || c == ChLt || c == ChGt || c == ChStar) begin
          held_d = c;
          mode_d = M_OPH;
        end else begin
          b = put(b, c, 1'b1, 1'b0, KIND_OP);
          b = put(b, 8'd0, 1'b0, 1'b1, KIND_OP);
        end
      end else if (is_bracket(c)) begin
        b = put(b, c, 1'b1, 1'b0, KIND_BRACKET);
        b = put(b, 8'd0, 1'b0, 1'b1, KIND_BRACKET);
      end else if (is_alpha(c) || is_wsym(c)) begin
        b      = put(b, c, 1'b1, 1'b0, KIND_WORD);
        mode_d = M_WORD;
      end
    end

    // The command end flushes held characters and closes the open token.
    if (last_char_i) begin
      unique case (mode_d)
        M_QUOTE, M_QESC: b = put(b, 8'd0, 1'b0, 1'b1, KIND_QUOTE);
        M_NUM:           b = put(b, 8'd0, 1'b0, 1'b1, KIND_NUMBER);
        M_WORD:          b = put(b, 8'd0, 1'b0, 1'b1, KIND_WORD);
        M_OPH: begin
          b = put(b, held_d, 1'b1, 1'b0, KIND_OP);
          b = put(b, 8'd0, 1'b0, 1'b1, KIND_OP);
        end
        M_DOTH: begin
          b = put(b, ChDot, 1'b1, 1'b0, KIND_WORD);
          b = put(b, 8'd0, 1'b0, 1'b1, KIND_WORD);
        end
        default: ;
      endcase
      if (b.count == '0) b = put(b, 8'd0, 1'b0, 1'b0, KIND_QUOTE);
      b.res[b.count - CountW'(1)].cmd_end = 1'b1;
      mode_d = M_IDLE;
      held_d = '0;
      dot_d  = 1'b0;
      drop_d = 1'b0;
    end
  end

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;
  assign push_o     = accept && (b.count != '0);
  assign bundle_o   = b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      held_q <= '0;
      dot_q  <= 1'b0;
      drop_q <= 1'b0;
    end else if (accept) begin
      mode_q <= mode_d;
      held_q <= held_d;
      dot_q  <= dot_d;
      drop_q <= drop_d;
    end
  end

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (b.count != '0 && b.count <= CountW'(MaxResults)))
    else $error("bundle pushed with a bad result count");

  a_last_marks_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_char_i) |-> (push_o && b.res[b.count - CountW'(1)].cmd_end))
    else $error("final character did not produce a command end");

  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_char_i) |=> (mode_q == M_IDLE && !dot_q && !drop_q))
    else $error("lexer state not cleared after command end");

endmodule

@@ design/clt_queue.sv @@
// Bundle queue between the lexer front end and the output side of the tokenizer.
// A small register queue; depends on clt_pkg.
module clt_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  clt_pkg::bundle_t wdata_i,
  input  logic             pop_i,
  output clt_pkg::bundle_t rdata_o,
  output logic             full_o,
  output logic             empty_o
);
  import clt_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  bundle_t           mem_q [Depth];
  logic [PtrW-1:0]   wptr_q, rptr_q;
  logic [CntW-1:0]   cnt_q;

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= next_ptr(wptr_q);
      if (pop_i)  rptr_q <= next_ptr(rptr_q);
      if (push_i && !pop_i)      cnt_q <= cnt_q + CntW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= wdata_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i) && !(pop_i && empty_o))
    else $error("queue pushed while full or popped while empty");

endmodule

@@ design/clt_back.sv @@
// Output side of the tokenizer: walks the results of the head bundle one per cycle, while
// the receiver is ready, into a registered output stage. Depends on clt_pkg.
module clt_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  clt_pkg::bundle_t head_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output clt_pkg::result_t out_o
);
  import clt_pkg::*;

  logic [CountW-1:0] idx_q;
  logic              valid_q;
  result_t           out_q;
  logic              load;
  logic              take;
  logic              last_slot;

  assign load      = !valid_q || out_ready_i;
  assign take      = load && !empty_i;
  assign last_slot = (idx_q == head_i.count - CountW'(1));
  assign pop_o     = take && last_slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (take) begin
        valid_q <= 1'b1;
        idx_q   <= last_slot ? '0 : idx_q + CountW'(1);
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) out_q <= head_i.res[idx_q];
  end

  assign out_valid_o = valid_q;
  assign out_o       = out_q;

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> (idx_q < head_i.count))
    else $error("result index beyond the head bundle");

  a_char_or_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && out_q.valid) |-> !out_q.tend)
    else $error("result carries both a character and a token end");

endmodule

@@ design/command_line_tokenizer_top.sv @@
// Top level of the command line tokenizer.
// Instantiates clt_front, clt_queue and clt_back; depends on clt_pkg.
//
// One character is accepted per cycle while the bundle queue has room. Each character
// yields zero to five result words, and the output side sends one word per cycle while
// the receiver is ready; the queue lets input and output overlap. The output rate is set
// by the single-word output register. The first result of an accepted character passes
// through the queue register and then the output register. A command ends with the word
// that has command_end set; the lexer is back in its reset state for the next character.
module command_line_tokenizer_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_in_i,
  input  logic       last_char_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       char_valid_o,
  output logic       token_end_o,
  output logic [2:0] token_kind_o,
  output logic       command_end_o
);
  import clt_pkg::*;

  bundle_t push_bundle;
  bundle_t head_bundle;
  logic    push;
  logic    pop;
  logic    full;
  logic    empty;
  result_t res;

  clt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_in_i    (char_in_i),
    .last_char_i  (last_char_i),
    .queue_full_i (full),
    .push_o       (push),
    .bundle_o     (push_bundle)
  );

  clt_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_bundle),
    .pop_i   (pop),
    .rdata_o (head_bundle),
    .full_o  (full),
    .empty_o (empty)
  );

  clt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_bundle),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (res)
  );

  assign out_char_o    = res.ch;
  assign char_valid_o  = res.valid;
  assign token_end_o   = res.tend;
  assign token_kind_o  = res.kind;
  assign command_end_o = res.cmd_end;

endmodule

@@ dv/clt_token_checker.sv @@
// Scoreboard for the command line tokenizer: predicts the result words of every
// accepted character and compares them with the words leaving the block.
// Depends on clt_pkg for the result format and the token kinds.
module clt_token_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  char_in_i,
  input  logic        last_char_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  out_char_i,
  input  logic        char_valid_i,
  input  logic        token_end_i,
  input  logic [2:0]  token_kind_i,
  input  logic        command_end_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import clt_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_QUOTE,
    MODE_ESCAPE,
    MODE_NUMBER,
    MODE_WORD,
    MODE_OP_HELD,
    MODE_DOT_HELD
  } lex_mode_e;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  lex_mode_e   mode_q;
  logic [7:0]  held_q;
  logic        dot_seen_q;
  logic        dropping_q;
  result_t     step_words[$];
  result_t     token_words_due[$];
  int unsigned mismatch_count;

  function automatic bit is_digit(logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return c inside {["A":"Z"], ["a":"z"]};
  endfunction

  function automatic bit is_word_sym(logic [7:0] c);
    return c inside {"\\", "/", ".", "[", "]"};
  endfunction

  function automatic bit is_word_cont(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || is_word_sym(c);
  endfunction

  function automatic bit is_op(logic [7:0] c);
    return c inside {"=", "!", "<", ">", "+", "-", "*", "/"};
  endfunction

  function automatic bit is_bracket(logic [7:0] c);
    return c inside {"(", ")", "{", "}"};
  endfunction

  function automatic void push_word(logic [7:0] ch, logic valid, logic tend, kind_e kind);
    result_t w;
    if (step_words.size() >= MaxResults) return;
    w.ch      = ch;
    w.valid   = valid;
    w.tend    = tend;
    w.kind    = kind;
    w.cmd_end = 1'b0;
    step_words.push_back(w);
  endfunction

  function automatic void emit_char(logic [7:0] ch, kind_e kind);
    push_word(ch, 1'b1, 1'b0, kind);
  endfunction

  function automatic void end_token(kind_e kind);
    push_word(CH_NUL, 1'b0, 1'b1, kind);
  endfunction

  function automatic void clear_lexer();
    mode_q     = MODE_IDLE;
    held_q     = CH_NUL;
    dot_seen_q = 1'b0;
    dropping_q = 1'b0;
  endfunction

  function automatic logic [7:0] unescape(logic [7:0] c);
    case (c)
      "n":     return CH_LF;
      "t":     return CH_TAB;
      "r":     return CH_CR;
      "0":     return CH_NUL;
      default: return c;
    endcase
  endfunction

  // Once a zero has appeared, the rest of the string up to its closing quote is dropped.
  function automatic void take_quoted(logic [7:0] v);
    if (dropping_q) return;
    if (v == CH_NUL) dropping_q = 1'b1;
    else emit_char(v, KIND_QUOTE);
  endfunction

  function automatic void open_token(logic [7:0] c);
    mode_q = MODE_IDLE;
    if (c == CH_QUOTE) begin
      mode_q     = MODE_QUOTE;
      dropping_q = 1'b0;
    end else if (is_digit(c)) begin
      emit_char(c, KIND_NUMBER);
      dot_seen_q = 1'b0;
      mode_q     = MODE_NUMBER;
    end else if (c == CH_DOT) begin
      held_q = c;
      mode_q = MODE_DOT_HELD;
    end else if (is_op(c)) begin
      if (c inside {"=", "!", "<", ">", "*"}) begin
        held_q = c;
        mode_q = MODE_OP_HELD;
      end else begin
        emit_char(c, KIND_OP);
        end_token(KIND_OP);
      end
    end else if (is_bracket(c)) begin
      emit_char(c, KIND_BRACKET);
      end_token(KIND_BRACKET);
    end else if (is_alpha(c) || is_word_sym(c)) begin
      emit_char(c, KIND_WORD);
      mode_q = MODE_WORD;
    end
  endfunction

  function automatic void tokenize_char(logic [7:0] c, logic last);
    bit      pair;
    result_t tail;
    step_words.delete();
    case (mode_q)
      MODE_QUOTE: begin
        if (c == CH_QUOTE) begin
          end_token(KIND_QUOTE);
          mode_q = MODE_IDLE;
        end else if (c == CH_BSLASH && !last) begin
          mode_q = MODE_ESCAPE;
        end else begin
          take_quoted(c);
        end
      end
      MODE_ESCAPE: begin
        take_quoted(unescape(c));
        mode_q = MODE_QUOTE;
      end
      MODE_NUMBER: begin
        if (is_digit(c)) begin
          emit_char(c, KIND_NUMBER);
        end else if (c == CH_DOT && !dot_seen_q) begin
          emit_char(c, KIND_NUMBER);
          dot_seen_q = 1'b1;
        end else begin
          end_token(KIND_NUMBER);
          open_token(c);
        end
      end
      MODE_WORD: begin
        if (is_word_cont(c)) begin
          emit_char(c, KIND_WORD);
        end else begin
          end_token(KIND_WORD);
          open_token(c);
        end
      end
      MODE_OP_HELD: begin
        pair = (c == CH_EQ && held_q inside {"=", "!", "<", ">"}) ||
               (c == CH_STAR && held_q == CH_STAR);
        emit_char(held_q, KIND_OP);
        mode_q = MODE_IDLE;
        if (pair) begin
          emit_char(c, KIND_OP);
          end_token(KIND_OP);
        end else begin
          end_token(KIND_OP);
          open_token(c);
        end
      end
      MODE_DOT_HELD: begin
        // A leading dot joins a number only when a digit follows it.
        if (is_digit(c)) begin
          emit_char(CH_DOT, KIND_NUMBER);
          emit_char(c, KIND_NUMBER);
          dot_seen_q = 1'b1;
          mode_q     = MODE_NUMBER;
        end else begin
          emit_char(CH_DOT, KIND_WORD);
          if (is_word_cont(c)) begin
            emit_char(c, KIND_WORD);
            mode_q = MODE_WORD;
          end else begin
            end_token(KIND_WORD);
            open_token(c);
          end
        end
      end
      default: open_token(c);
    endcase

    if (last) begin
      case (mode_q)
        MODE_QUOTE, MODE_ESCAPE: end_token(KIND_QUOTE);
        MODE_NUMBER: end_token(KIND_NUMBER);
        MODE_WORD: end_token(KIND_WORD);
        MODE_OP_HELD: begin
          emit_char(held_q, KIND_OP);
          end_token(KIND_OP);
        end
        MODE_DOT_HELD: begin
          emit_char(CH_DOT, KIND_WORD);
          end_token(KIND_WORD);
        end
        default: ;
      endcase
      if (step_words.size() == 0) push_word(CH_NUL, 1'b0, 1'b0, KIND_QUOTE);
      tail = step_words.pop_back();
      tail.cmd_end = 1'b1;
      step_words.push_back(tail);
      clear_lexer();
    end
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t due;
    if (!rst_ni) begin
      clear_lexer();
      token_words_due.delete();
      mismatch_count = 0;
      pending_o    <= 0;
      mismatches_o <= 0;
    end else begin
      // Outputs are checked first: a word leaving now cannot stem from a character
      // accepted at this same edge.
      if (out_valid_i && out_ready_i) begin
        if (token_words_due.size() == 0) begin
          report_mismatch($sformatf("word %02h valid %b end %b kind %0d cmd_end %b not expected",
                                    out_char_i, char_valid_i, token_end_i, token_kind_i,
                                    command_end_i));
        end else begin
          due = token_words_due.pop_front();
          if (out_char_i !== due.ch)
            report_mismatch($sformatf("out_char expected %02h got %02h", due.ch, out_char_i));
          if (char_valid_i !== due.valid)
            report_mismatch($sformatf("char_valid expected %b got %b", due.valid, char_valid_i));
          if (token_end_i !== due.tend)
            report_mismatch($sformatf("token_end expected %b got %b", due.tend, token_end_i));
          if (token_kind_i !== due.kind)
            report_mismatch($sformatf("token_kind expected %0d got %0d", due.kind, token_kind_i));
          if (command_end_i !== due.cmd_end)
            report_mismatch($sformatf("command_end expected %b got %b", due.cmd_end,
                                      command_end_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        tokenize_char(char_in_i, last_char_i);
        foreach (step_words[i]) token_words_due.push_back(step_words[i]);
      end
      pending_o    <= token_words_due.size();
      mismatches_o <= mismatch_count;
    end
  end

endmodule

@@ dv/testbench.sv @@
// Top of the command line tokenizer testbench: clock, reset, command stimulus,
// receiver back-pressure and the verdict. Depends on command_line_tokenizer_top
// and clt_token_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          ClkPeriodNs   = 12;
  localparam int unsigned PhaseItems    = 60;
  localparam int unsigned HoldOffCycles = 80;
  localparam int unsigned DrainCycles   = 16;
  localparam int unsigned WatchdogLimit = 2000;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic [7:0]  char_in    = 8'h00;
  logic        last_char  = 1'b0;
  logic        out_ready  = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [7:0]  out_char;
  logic        char_valid;
  logic        token_end;
  logic [2:0]  token_kind;
  logic        command_end;
  int unsigned mismatches;
  int unsigned pending;

  int unsigned send_idle_pct     = 0;
  int unsigned recv_idle_pct     = 0;
  int unsigned hold_off_requests = 0;
  logic [7:0]  cmd_text[$];

  always #(ClkPeriodNs / 2) clk = ~clk;

  command_line_tokenizer_top dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .char_in_i     (char_in),
    .last_char_i   (last_char),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .out_char_o    (out_char),
    .char_valid_o  (char_valid),
    .token_end_o   (token_end),
    .token_kind_o  (token_kind),
    .command_end_o (command_end)
  );

  clt_token_checker token_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .char_in_i     (char_in),
    .last_char_i   (last_char),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_char_i    (out_char),
    .char_valid_i  (char_valid),
    .token_end_i   (token_end),
    .token_kind_i  (token_kind),
    .command_end_i (command_end),
    .mismatches_o  (mismatches),
    .pending_o     (pending)
  );

  function automatic logic [7:0] pick(string chars);
    return chars[$urandom_range(chars.len() - 1)];
  endfunction

  function automatic logic [7:0] space_char();
    return ($urandom_range(1) == 1) ? CH_SPACE : 8'($urandom_range(9, 13));
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) cmd_text.push_back(s[i]);
  endfunction

  // Sends the queued command one word at a time, last_char on its final word.
  task automatic send_command();
    for (int i = 0; i < cmd_text.size(); i++) begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid  <= 1'b1;
      char_in   <= cmd_text[i];
      last_char <= (i == cmd_text.size() - 1);
      do @(posedge clk); while (!in_ready);
      @(negedge clk);
    end
    cmd_text.delete();
  endtask

  // Mostly well-formed commands built from random tokens, with some pure noise.
  task automatic run_phase(input int unsigned sender_pct, input int unsigned receiver_pct,
                           input bit hold_off);
    int unsigned sent;
    bit          stalled;
    sent    = 0;
    stalled = 1'b0;
    send_idle_pct = sender_pct;
    recv_idle_pct <= receiver_pct;
    while (sent < PhaseItems) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 8)) cmd_text.push_back(8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(1, 5)) begin
          case ($urandom_range(9))
            0, 1: begin
              cmd_text.push_back(CH_QUOTE);
              repeat ($urandom_range(5)) begin
                case ($urandom_range(5))
                  0: begin
                    cmd_text.push_back(CH_BSLASH);
                    cmd_text.push_back(pick("ntr0xq\"\\"));
                  end
                  1: cmd_text.push_back(($urandom_range(3) == 0) ?
                                        CH_NUL : 8'($urandom_range(128, 255)));
                  default: cmd_text.push_back(8'($urandom_range(32, 126)));
                endcase
              end
              if ($urandom_range(4) != 0) cmd_text.push_back(CH_QUOTE);
            end
            2, 3: begin
              if ($urandom_range(3) == 0) cmd_text.push_back(CH_DOT);
              repeat ($urandom_range(1, 3)) cmd_text.push_back(pick("0123456789"));
              if ($urandom_range(1) == 1) begin
                cmd_text.push_back(CH_DOT);
                repeat ($urandom_range(2)) cmd_text.push_back(pick("0123456789"));
              end
              if ($urandom_range(4) == 0) cmd_text.push_back(CH_DOT);
            end
            4: begin
              cmd_text.push_back(pick("=!<>+-*/"));
              if ($urandom_range(1) == 1) cmd_text.push_back(pick("=*"));
            end
            5: cmd_text.push_back(pick("(){}"));
            6, 7: begin
              cmd_text.push_back(pick("abcxyzAMQZkr\\.[]"));
              repeat ($urandom_range(4)) cmd_text.push_back(pick("aeqzBNZ09517\\/.[]"));
            end
            8: cmd_text.push_back(space_char());
            default: cmd_text.push_back(8'($urandom_range(255)));
          endcase
          if ($urandom_range(1) == 1) cmd_text.push_back(space_char());
        end
      end
      sent += cmd_text.size();
      if (hold_off && !stalled && sent >= PhaseItems / 4) begin
        hold_off_requests <= hold_off_requests + 1;
        stalled = 1'b1;
      end
      send_command();
    end
  endtask

  // Receiver: random ready, or a long hold-off whenever the stimulus asks for one.
  initial begin : receiver
    int unsigned hold_offs_done;
    hold_offs_done = 0;
    forever begin
      @(negedge clk);
      if (hold_offs_done != hold_off_requests) begin
        hold_offs_done++;
        out_ready <= 1'b0;
        for (int unsigned held = 1; held < HoldOffCycles; held++) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("command_line_tokenizer_top verification failed");
    $finish;
  end

  initial begin : stimulus
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 7;
    recv_idle_pct <= 56;

    // Escaped newline, then an escaped zero that drops the rest of the string.
    add_text("\"\\n\\0x\"");
    send_command();
    // Backslash as the last word inside an open string stays a backslash.
    add_text("\"\\");
    send_command();
    // A lone opening quote gives an empty quoted token.
    add_text("\"");
    send_command();
    // Raw zero byte in an unclosed string.
    cmd_text.push_back(CH_QUOTE);
    cmd_text.push_back(CH_NUL);
    add_text("b");
    send_command();
    // Leading dot number, second dot, then a held operator flushed at the end.
    add_text(".5.3>");
    send_command();
    // Word, two-character operators, a dot before a bracket.
    add_text("a<=**.)");
    send_command();
    // High code and zero outside a token, a plain operator, a dot flushed as a word.
    cmd_text.push_back(8'hC3);
    cmd_text.push_back(CH_NUL);
    add_text("-.");
    send_command();
    // Whitespace only: just the end-of-command marker.
    cmd_text.push_back(CH_SPACE);
    send_command();

    run_phase(7, 56, 1'b0);
    run_phase(56, 7, 1'b0);
    run_phase(0, 0, 1'b1);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("command_line_tokenizer_top verification clean");
    end else begin
      $display("command_line_tokenizer_top verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/clt_pkg.sv
design/clt_front.sv
design/clt_queue.sv
design/clt_back.sv
design/command_line_tokenizer_top.sv
dv/clt_token_checker.sv
dv/testbench.sv
